// File: rtl/dvrt_pkg.sv
// Shared types and constants of the distance-vector route table.
// Used by dvrt_ctrl, dvrt_dpath and distance_vector_route_table; no dependencies.
`timescale 1ns / 1ps

package dvrt_pkg;

    // Request selector codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_EXPORT = 2'd2;

    // Result status codes
    localparam logic [2:0] STS_INSERTED = 3'd0;
    localparam logic [2:0] STS_REPLACED = 3'd1;
    localparam logic [2:0] STS_IGNORED  = 3'd2;
    localparam logic [2:0] STS_FULL     = 3'd3;
    localparam logic [2:0] STS_EXPORTED = 3'd4;

    // Wire code for an unreachable distance
    localparam logic [31:0] INF_CODE = 32'h7FFF_FFFF;

    // Reset value of the infinity metric
    localparam logic [7:0] INF_RESET = 8'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_SUM,
        ST_DECIDE,
        ST_EXPORT
    } state_t;

    // One stored route
    typedef struct packed {
        logic        direct;
        logic [31:0] next_hop;
        logic [31:0] distance;
        logic [5:0]  prefix;
        logic [31:0] address;
    } entry_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       scan_clr;
        logic       scan_rd;
        logic       sum_load;
        logic       mem_we;
        logic       count_inc;
        logic       emit_single;
        logic       emit_entry;
        logic [2:0] code;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic       count_zero;
        logic       full;
        logic       scan_done;
        logic       rd_vld;
        logic       dest_found;
        logic       sum_lt;
    } stat_t;

endpackage

// File: rtl/dvrt_dpath.sv
// Datapath of the route table: slot memory, fill count, request registers,
// scan match logic, saturating sum and result registers. Depends on dvrt_pkg.
`timescale 1ns / 1ps

module dvrt_dpath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          req_type,
    input  logic [31:0]         route_address,
    input  logic [5:0]          prefix_len,
    input  logic [31:0]         distance_in,
    input  logic [31:0]         sender_address,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  dvrt_pkg::cmd_t      cmd,
    output dvrt_pkg::stat_t     stat,
    output logic                result_valid,
    output logic [2:0]          status,
    output logic [31:0]         out_address,
    output logic [5:0]          out_prefix_len,
    output logic [31:0]         out_distance_code,
    output logic [31:0]         out_next_hop,
    output logic                out_direct,
    output logic                entry_valid,
    output logic                last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Slot memory, filled in order and never freed
    dvrt_pkg::entry_t mem [0:TABLE_DEPTH-1];

    logic [7:0]       inf_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    dvrt_pkg::entry_t rd_data_reg;

    logic [1:0]       req_type_reg;
    logic [31:0]      req_addr_reg;
    logic [5:0]       req_pfx_reg;
    logic [31:0]      req_dist_reg;
    logic [31:0]      req_sender_reg;

    logic             sender_found_reg;
    logic [31:0]      sender_dist_reg;
    logic             dest_found_reg;
    logic [IDX_W-1:0] dest_idx_reg;
    logic [31:0]      dest_dist_reg;
    logic [31:0]      sum_reg;

    logic             res_valid_reg;
    logic [2:0]       res_status_reg;
    logic [31:0]      res_addr_reg;
    logic [5:0]       res_pfx_reg;
    logic [31:0]      res_dist_reg;
    logic [31:0]      res_nh_reg;
    logic             res_direct_reg;
    logic             res_entry_reg;
    logic             res_last_reg;

    logic [31:0]      adv_dist;
    logic [32:0]      sum_wide;
    logic [31:0]      sum_next;
    logic [IDX_W-1:0] wr_idx;
    dvrt_pkg::entry_t wr_data;
    logic             rd_is_last;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inf_reg <= dvrt_pkg::INF_RESET;
        end
        else if (cfg_we)
        begin
            inf_reg <= cfg_wdata;
        end
    end

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg   <= req_type;
            req_addr_reg   <= route_address;
            req_pfx_reg    <= prefix_len;
            req_dist_reg   <= distance_in;
            req_sender_reg <= sender_address;
        end
    end

    // Fill count, scan pointer and read-valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.scan_clr)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            rd_vld_reg <= cmd.scan_rd;
        end
    end

    // Write address and data: replace in place when the destination was found
    always_comb
    begin
        wr_idx = dest_found_reg ? dest_idx_reg : count_reg[IDX_W-1:0];
        wr_data.address = req_addr_reg;
        wr_data.prefix  = req_pfx_reg;
        if (req_type_reg == dvrt_pkg::REQ_ADD)
        begin
            wr_data.distance = req_dist_reg;
            wr_data.next_hop = '0;
            wr_data.direct   = 1'b1;
        end
        else
        begin
            wr_data.distance = sum_reg;
            wr_data.next_hop = req_sender_reg;
            wr_data.direct   = 1'b0;
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (cmd.scan_rd)
        begin
            rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
            rd_idx_reg  <= scan_idx_reg[IDX_W-1:0];
        end
    end

    // Match the read slot against sender and destination, first hit wins
    always_ff @(posedge clk)
    begin
        if (cmd.scan_clr)
        begin
            sender_found_reg <= 1'b0;
            sender_dist_reg  <= '0;
            dest_found_reg   <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (!sender_found_reg && rd_data_reg.address == req_sender_reg)
            begin
                sender_found_reg <= 1'b1;
                sender_dist_reg  <= rd_data_reg.distance;
            end
            if (!dest_found_reg && rd_data_reg.address == req_addr_reg)
            begin
                dest_found_reg <= 1'b1;
                dest_idx_reg   <= rd_idx_reg;
                dest_dist_reg  <= rd_data_reg.distance;
            end
        end
    end

    // Decode the advertised distance and add the sender's distance, saturating
    always_comb
    begin
        adv_dist = (req_dist_reg == dvrt_pkg::INF_CODE) ? {24'd0, inf_reg} : req_dist_reg;
        sum_wide = {1'b0, adv_dist} + {1'b0, sender_dist_reg};
        sum_next = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign rd_is_last = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg;

    // Result registers: one beat per strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.emit_single | cmd.emit_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_entry)
        begin
            res_status_reg <= dvrt_pkg::STS_EXPORTED;
            res_addr_reg   <= rd_data_reg.address;
            res_pfx_reg    <= rd_data_reg.prefix;
            res_dist_reg   <= (rd_data_reg.distance >= {24'd0, inf_reg}) ?
                              dvrt_pkg::INF_CODE : rd_data_reg.distance;
            res_nh_reg     <= rd_data_reg.direct ? 32'd0 : rd_data_reg.next_hop;
            res_direct_reg <= rd_data_reg.direct;
            res_entry_reg  <= 1'b1;
            res_last_reg   <= rd_is_last;
        end
        else if (cmd.emit_single)
        begin
            res_status_reg <= cmd.code;
            res_addr_reg   <= '0;
            res_pfx_reg    <= '0;
            res_dist_reg   <= '0;
            res_nh_reg     <= '0;
            res_direct_reg <= 1'b0;
            res_entry_reg  <= 1'b0;
            res_last_reg   <= 1'b1;
        end
    end

    // Status toward the controller
    always_comb
    begin
        stat.count_zero = (count_reg == '0);
        stat.full       = (count_reg == CNT_W'(TABLE_DEPTH));
        stat.scan_done  = (scan_idx_reg == count_reg);
        stat.rd_vld     = rd_vld_reg;
        stat.dest_found = dest_found_reg;
        stat.sum_lt     = (sum_reg < dest_dist_reg);
    end

    assign result_valid      = res_valid_reg;
    assign status            = res_status_reg;
    assign out_address       = res_addr_reg;
    assign out_prefix_len    = res_pfx_reg;
    assign out_distance_code = res_dist_reg;
    assign out_next_hop      = res_nh_reg;
    assign out_direct        = res_direct_reg;
    assign entry_valid       = res_entry_reg;
    assign last              = res_last_reg;

endmodule

// File: rtl/dvrt_ctrl.sv
// Controller of the route table: sequences add, update and export requests
// and drives datapath commands. Depends on dvrt_pkg.
`timescale 1ns / 1ps

module dvrt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      req_type,
    input  dvrt_pkg::stat_t stat,
    output dvrt_pkg::cmd_t  cmd,
    output logic            busy
);

    dvrt_pkg::state_t state_reg;
    dvrt_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dvrt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = dvrt_pkg::STS_INSERTED;
        case (state_reg)
            dvrt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    cmd.scan_clr = 1'b1;
                    case (req_type)
                        dvrt_pkg::REQ_ADD:    state_next = dvrt_pkg::ST_ADD;
                        dvrt_pkg::REQ_UPDATE: state_next = dvrt_pkg::ST_SCAN;
                        dvrt_pkg::REQ_EXPORT: state_next = dvrt_pkg::ST_EXPORT;
                        default:              state_next = dvrt_pkg::ST_IDLE;
                    endcase
                end
            end
            dvrt_pkg::ST_ADD:
            begin
                cmd.emit_single = 1'b1;
                if (stat.full)
                begin
                    cmd.code = dvrt_pkg::STS_FULL;
                end
                else
                begin
                    cmd.mem_we    = 1'b1;
                    cmd.count_inc = 1'b1;
                    cmd.code      = dvrt_pkg::STS_INSERTED;
                end
                state_next = dvrt_pkg::ST_IDLE;
            end
            dvrt_pkg::ST_SCAN:
            begin
                // Issue one slot read per cycle, drain the last read
                cmd.scan_rd = !stat.scan_done;
                if (stat.scan_done && !stat.rd_vld)
                begin
                    state_next = dvrt_pkg::ST_SUM;
                end
            end
            dvrt_pkg::ST_SUM:
            begin
                cmd.sum_load = 1'b1;
                state_next   = dvrt_pkg::ST_DECIDE;
            end
            dvrt_pkg::ST_DECIDE:
            begin
                cmd.emit_single = 1'b1;
                if (!stat.dest_found)
                begin
                    if (stat.full)
                    begin
                        cmd.code = dvrt_pkg::STS_FULL;
                    end
                    else
                    begin
                        cmd.mem_we    = 1'b1;
                        cmd.count_inc = 1'b1;
                        cmd.code      = dvrt_pkg::STS_INSERTED;
                    end
                end
                else if (stat.sum_lt)
                begin
                    cmd.mem_we = 1'b1;
                    cmd.code   = dvrt_pkg::STS_REPLACED;
                end
                else
                begin
                    cmd.code = dvrt_pkg::STS_IGNORED;
                end
                state_next = dvrt_pkg::ST_IDLE;
            end
            dvrt_pkg::ST_EXPORT:
            begin
                if (stat.count_zero)
                begin
                    // Empty table: one beat with no entry
                    cmd.emit_single = 1'b1;
                    cmd.code        = dvrt_pkg::STS_EXPORTED;
                    state_next      = dvrt_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.scan_rd    = !stat.scan_done;
                    cmd.emit_entry = stat.rd_vld;
                    if (stat.scan_done && !stat.rd_vld)
                    begin
                        state_next = dvrt_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dvrt_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != dvrt_pkg::ST_IDLE);

endmodule

// File: rtl/distance_vector_route_table.sv
// Distance-vector route table, top level: controller plus datapath.
// Depends on dvrt_pkg, dvrt_ctrl and dvrt_dpath.
//
// A request is taken when start is high and busy is low. An update reads the
// table one slot read per cycle to find sender and destination, drains the
// last read, then forms the sum and takes the decision; an export reads the
// occupied slots one by one as well, through the single slot memory read port.
// Every result appears for exactly one cycle with result_valid high, in the
// cycle after the controller produces it; the receiver cannot stall, so it
// must take each beat as it comes. An export delivers one beat per occupied
// slot, in slot order, with last on the final one. The infinity metric is
// written through cfg_we/cfg_wdata; the user must write it only while idle,
// as the block itself does not enforce this.
`timescale 1ns / 1ps

module distance_vector_route_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] route_address,
    input  logic [5:0]  prefix_len,
    input  logic [31:0] distance_in,
    input  logic [31:0] sender_address,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [31:0] out_address,
    output logic [5:0]  out_prefix_len,
    output logic [31:0] out_distance_code,
    output logic [31:0] out_next_hop,
    output logic        out_direct,
    output logic        entry_valid,
    output logic        last
);

    dvrt_pkg::cmd_t  cmd;
    dvrt_pkg::stat_t stat;

    dvrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    dvrt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_type          (req_type),
        .route_address     (route_address),
        .prefix_len        (prefix_len),
        .distance_in       (distance_in),
        .sender_address    (sender_address),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .cmd               (cmd),
        .stat              (stat),
        .result_valid      (result_valid),
        .status            (status),
        .out_address       (out_address),
        .out_prefix_len    (out_prefix_len),
        .out_distance_code (out_distance_code),
        .out_next_hop      (out_next_hop),
        .out_direct        (out_direct),
        .entry_valid       (entry_valid),
        .last              (last)
    );

endmodule
